>>> rtl/core/cats_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cats_pkg
// Types, codes and helper functions of the cpu affinity target selector.
// ----------------------------------------------------------------------------
package cats_pkg;

	localparam int CPU_COUNT = 64;
	localparam int MAP_BITS  = 64;

	localparam logic [63:0] CPU_MASK = (CPU_COUNT >= 64) ? {64{1'b1}} :
		((64'd1 << CPU_COUNT) - 64'd1);
	localparam logic [63:0] MAP_MASK = (MAP_BITS >= 64) ? {64{1'b1}} :
		((64'd1 << MAP_BITS) - 64'd1);
	localparam logic [5:0] GRAN_MASK = 6'(MAP_BITS - 1);

	localparam logic [5:0]  INFO_WORDS  = 6'd2;
	localparam logic [5:0]  PLACE_WORDS = 6'd5;
	localparam logic [5:0]  IDLE_WORDS  = 6'd3;
	localparam logic [31:0] PRIO_MAX    = 32'd255;
	localparam logic [23:0] OFFSET_MASK = 24'hffffff;

	localparam logic [63:0] ONLINE_RESET  = 64'd1;
	localparam logic [31:0] QUANTUM_RESET = 32'd10000;

	typedef enum logic [1:0] {
		MODE_INFO  = 2'd0,
		MODE_PLACE = 2'd1,
		MODE_IDLE  = 2'd2,
		MODE_NOSYS = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_INVAL = 2'd1,
		ST_NOSYS = 2'd2
	} status_t;

	typedef enum logic {
		REG_ONLINE  = 1'b0,
		REG_QUANTUM = 1'b1
	} reg_idx_t;

	// per-cpu view of a group bitmap: bit k takes group k >> gran
	function automatic logic [63:0] expand_map(input logic [63:0] map,
	                                           input logic [5:0] gran);
		logic [63:0] e;
		logic [5:0]  idx;
		e = '0;
		for (int k = 0; k < 64; k++) begin
			idx  = 6'(k) >> gran;
			e[k] = map[idx];
		end
		return e;
	endfunction

	// or together neighbor bits gran times, group d ends up in bit d
	function automatic logic [63:0] fold_groups(input logic [63:0] v,
	                                            input logic [2:0] gran);
		logic [63:0] cur;
		logic [63:0] nxt;
		cur = v;
		for (int j = 0; j < 6; j++) begin
			nxt = '0;
			for (int i = 0; i < 32; i++) begin
				nxt[i] = cur[2*i] | cur[2*i+1];
			end
			if (3'(j) < gran) begin
				cur = nxt;
			end
		end
		return cur;
	endfunction

	// lowest set bit
	function automatic logic [5:0] first_set(input logic [63:0] v);
		logic [5:0] idx;
		idx = '0;
		for (int i = 63; i >= 0; i--) begin
			if (v[i]) begin
				idx = 6'(i);
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/cpu_affinity_target_select.sv
`timescale 1ns / 1ps
`default_nettype none
// an accepted beat passes stage registers 1 to 4 in order to the master side
// throughput: one beat per cycle unless a full pipe waits on m_tready; each
// of the four stages holds one request, and empty stages fill during a stall
// reset: all stage valid bits clear, online_mask returns to 1 (cpu 0 only)
// and default_quantum to 10000
// ----------------------------------------------------------------------------
// cpu_affinity_target_select
// Four-stage pipeline that resolves an affinity set into a target cpu,
// reports online groups in info mode and clamps placement parameters.
// ----------------------------------------------------------------------------
module cpu_affinity_target_select (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// config write port
	input  wire logic         cfg_we,
	input  wire logic [0:0]   cfg_index,
	input  wire logic [63:0]  cfg_data,
	// request stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// mode, msg_words, thread_ok, set_offset, set_granularity, set_map,
	// thread_cpu, caller_cpu, priority_req, quantum, 5 pad bits
	input  wire logic [183:0] s_tdata,
	// result stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// status, target_cpu, target_valid, priority_out, quantum_out,
	// group_map, cpu_total
	output logic [119:0]      m_tdata
);

	// ---------------- config registers ----------------
	logic [63:0] online_mask_q;
	logic [31:0] default_quantum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			online_mask_q     <= cats_pkg::ONLINE_RESET;
			default_quantum_q <= cats_pkg::QUANTUM_RESET;
		end else if (cfg_we) begin
			case (cats_pkg::reg_idx_t'(cfg_index))
				cats_pkg::REG_ONLINE:  online_mask_q     <= cfg_data;
				cats_pkg::REG_QUANTUM: default_quantum_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// ---------------- input unpack ----------------
	cats_pkg::mode_t in_mode;
	logic [5:0]      in_words;
	logic            in_thread_ok;
	logic [23:0]     in_offset;
	logic [5:0]      in_gran;
	logic [63:0]     in_map;
	logic [5:0]      in_tcpu;
	logic [5:0]      in_ccpu;
	logic [31:0]     in_prio;
	logic [31:0]     in_quant;

	assign in_mode      = cats_pkg::mode_t'(s_tdata[1:0]);
	assign in_words     = s_tdata[7:2];
	assign in_thread_ok = s_tdata[8];
	assign in_offset    = s_tdata[32:9];
	assign in_gran      = s_tdata[38:33];
	assign in_map       = s_tdata[102:39];
	assign in_tcpu      = s_tdata[108:103];
	assign in_ccpu      = s_tdata[114:109];
	assign in_prio      = s_tdata[146:115];
	assign in_quant     = s_tdata[178:147];

	// ---------------- stage enables ----------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4    = !v_s4 || m_tready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;
	assign m_tvalid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// ---------------- stage 1: decode, offset and base ----------------
	logic [5:0]  gran_m;
	logic [23:0] off_c;
	logic [63:0] base_c;
	logic        words_ok_c;

	assign gran_m = in_gran & cats_pkg::GRAN_MASK;
	assign off_c  = in_offset & (cats_pkg::OFFSET_MASK << gran_m);
	assign base_c = {40'd0, off_c} << gran_m;

	always_comb begin
		case (in_mode)
			cats_pkg::MODE_INFO:  words_ok_c = in_words >= cats_pkg::INFO_WORDS;
			cats_pkg::MODE_PLACE: words_ok_c = (in_words >= cats_pkg::PLACE_WORDS)
			                                   && in_thread_ok;
			cats_pkg::MODE_IDLE:  words_ok_c = in_words >= cats_pkg::IDLE_WORDS;
			default:              words_ok_c = 1'b0;
		endcase
	end

	cats_pkg::mode_t mode_s1;
	logic        req_ok_s1;
	logic        base_ok_s1;
	logic [5:0]  base6_s1;
	logic        off_ok_s1;
	logic [5:0]  off6_s1;
	logic [2:0]  gfold_s1;
	logic [63:0] exp_s1;
	logic [5:0]  tcpu_s1;
	logic [5:0]  ccpu_s1;
	logic [7:0]  prio_s1;
	logic [31:0] quant_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mode_s1    <= in_mode;
			req_ok_s1  <= words_ok_c;
			base_ok_s1 <= base_c < 64'(cats_pkg::CPU_COUNT);
			base6_s1   <= base_c[5:0];
			off_ok_s1  <= off_c[23:6] == '0;
			off6_s1    <= off_c[5:0];
			gfold_s1   <= (gran_m >= 6'd6) ? 3'd6 : gran_m[2:0];
			exp_s1     <= cats_pkg::expand_map(in_map & cats_pkg::MAP_MASK, gran_m);
			tcpu_s1    <= in_tcpu;
			ccpu_s1    <= in_ccpu;
			prio_s1    <= (in_prio > cats_pkg::PRIO_MAX) ? cats_pkg::PRIO_MAX[7:0]
			                                             : in_prio[7:0];
			quant_s1   <= (in_quant != '0) ? in_quant : default_quantum_q;
		end
	end

	// ---------------- stage 2: set membership ----------------
	logic [63:0] online_c;
	logic [63:0] memb_c;

	assign online_c = online_mask_q & cats_pkg::CPU_MASK;
	assign memb_c   = off_ok_s1 ? (exp_s1 << off6_s1) : '0;

	cats_pkg::mode_t mode_s2;
	logic        req_ok_s2;
	logic        base_ok_s2;
	logic [2:0]  gfold_s2;
	logic [63:0] cand_s2;
	logic [63:0] shifted_s2;
	logic        tin_s2;
	logic        cin_s2;
	logic [5:0]  tcpu_s2;
	logic [5:0]  ccpu_s2;
	logic [7:0]  prio_s2;
	logic [31:0] quant_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			mode_s2    <= mode_s1;
			req_ok_s2  <= req_ok_s1;
			base_ok_s2 <= base_ok_s1;
			gfold_s2   <= gfold_s1;
			cand_s2    <= memb_c & online_c;
			shifted_s2 <= online_c >> base6_s1;
			tin_s2     <= memb_c[tcpu_s1];
			cin_s2     <= memb_c[ccpu_s1];
			tcpu_s2    <= tcpu_s1;
			ccpu_s2    <= ccpu_s1;
			prio_s2    <= prio_s1;
			quant_s2   <= quant_s1;
		end
	end

	// ---------------- stage 3: first cpu and group fold ----------------
	cats_pkg::mode_t mode_s3;
	logic        req_ok_s3;
	logic        base_ok_s3;
	logic [5:0]  first_s3;
	logic        found_s3;
	logic [63:0] gmap_s3;
	logic        tin_s3;
	logic        cin_s3;
	logic [5:0]  tcpu_s3;
	logic [5:0]  ccpu_s3;
	logic [7:0]  prio_s3;
	logic [31:0] quant_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			mode_s3    <= mode_s2;
			req_ok_s3  <= req_ok_s2;
			base_ok_s3 <= base_ok_s2;
			first_s3   <= cats_pkg::first_set(cand_s2);
			found_s3   <= cand_s2 != '0;
			gmap_s3    <= cats_pkg::fold_groups(shifted_s2, gfold_s2) & cats_pkg::MAP_MASK;
			tin_s3     <= tin_s2;
			cin_s3     <= cin_s2;
			tcpu_s3    <= tcpu_s2;
			ccpu_s3    <= ccpu_s2;
			prio_s3    <= prio_s2;
			quant_s3   <= quant_s2;
		end
	end

	// ---------------- stage 4: result select ----------------
	cats_pkg::status_t st_c;
	logic [5:0]  tgt_c;
	logic        tval_c;
	logic [7:0]  pout_c;
	logic [31:0] qout_c;
	logic [63:0] gmap_c;
	logic [6:0]  total_c;

	always_comb begin
		st_c    = cats_pkg::ST_OK;
		tgt_c   = '0;
		tval_c  = 1'b0;
		pout_c  = '0;
		qout_c  = '0;
		gmap_c  = '0;
		total_c = '0;
		case (mode_s3)
			cats_pkg::MODE_INFO: begin
				if (!req_ok_s3 || !base_ok_s3) begin
					st_c = cats_pkg::ST_INVAL;
				end else begin
					gmap_c  = gmap_s3;
					total_c = 7'(cats_pkg::CPU_COUNT);
				end
			end
			cats_pkg::MODE_PLACE: begin
				if (!req_ok_s3) begin
					st_c = cats_pkg::ST_INVAL;
				end else begin
					// keep the thread's cpu, then the caller's, then first online
					if (tin_s3) begin
						tgt_c  = tcpu_s3;
						tval_c = 1'b1;
					end else if (cin_s3) begin
						tgt_c  = ccpu_s3;
						tval_c = 1'b1;
					end else if (found_s3) begin
						tgt_c  = first_s3;
						tval_c = 1'b1;
					end
					pout_c = prio_s3;
					qout_c = quant_s3;
				end
			end
			cats_pkg::MODE_IDLE: begin
				if (!req_ok_s3 || !found_s3) begin
					st_c = cats_pkg::ST_INVAL;
				end else begin
					tgt_c  = first_s3;
					tval_c = 1'b1;
				end
			end
			default: st_c = cats_pkg::ST_NOSYS;
		endcase
	end

	cats_pkg::status_t status_s4;
	logic [5:0]  tgt_s4;
	logic        tval_s4;
	logic [7:0]  pout_s4;
	logic [31:0] qout_s4;
	logic [63:0] gmap_s4;
	logic [6:0]  total_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			status_s4 <= st_c;
			tgt_s4    <= tgt_c;
			tval_s4   <= tval_c;
			pout_s4   <= pout_c;
			qout_s4   <= qout_c;
			gmap_s4   <= gmap_c;
			total_s4  <= total_c;
		end
	end

	assign m_tdata = {total_s4, gmap_s4, qout_s4, pout_s4, tval_s4, tgt_s4, status_s4};

	// ---------------- assertions ----------------
	a_accept_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_s1)
		else $error("accepted beat did not enter stage 1");

	a_stall_holds_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !en_s2) |=> v_s2)
		else $error("stalled stage 2 beat was dropped");

	a_error_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && status_s4 != cats_pkg::ST_OK) |->
		(!tval_s4 && qout_s4 == '0 && gmap_s4 == '0 && total_s4 == '0))
		else $error("error result carries nonzero fields");

	a_gmap_info_only: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && gmap_s4 != '0) |-> (total_s4 == 7'(cats_pkg::CPU_COUNT)))
		else $error("group map set outside an ok info result");

endmodule
`default_nettype wire
